FILE: sv/lbmc_pkg.sv
// Shared constants and width helpers for the D2Q5 BGK collision pipeline.
package lbmc_pkg;

    localparam int VEL_FRAC  = 14;
    localparam int TAU_FRAC  = 14;
    localparam int TAU_WIDTH = 15;
    localparam logic [TAU_WIDTH-1:0] TAU_RESET = 15'd16384;

    localparam int NUM_LANES = 5;
    localparam int LANE_REST  = 0;
    localparam int LANE_EAST  = 1;
    localparam int LANE_NORTH = 2;
    localparam int LANE_WEST  = 3;
    localparam int LANE_SOUTH = 4;

    // Quotient bits resolved by one divide-by-three stage.
    localparam int DIV_STEP = 8;

    // Width of the signed factor (1 +/- 3u) in Q.14, wide enough for any velocity.
    function automatic int fac_width(input int vel_w);
        int fw;
        fw = (vel_w > VEL_FRAC) ? vel_w + 3 : VEL_FRAC + 3;
        return fw;
    endfunction

    // Number of divide-by-three stages needed for the equilibrium magnitude.
    function automatic int div_stages(input int dist_w, input int vel_w);
        int pw;
        int mw;
        pw = dist_w + 3 + fac_width(vel_w);
        mw = pw - VEL_FRAC - 1;
        return (mw + DIV_STEP - 1) / DIV_STEP;
    endfunction

endpackage

FILE: sv/lbmc_div3.sv
// One registered stage of an unsigned divide by three, eight quotient bits per stage.
module lbmc_div3 #(
    parameter int NUM_W  = 40,
    parameter int BIT_HI = 39
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [1:0]       i_rem,
    input  logic             i_neg,
    output logic [NUM_W-1:0] o_num,
    output logic [1:0]       o_rem,
    output logic             o_neg
);
    import lbmc_pkg::*;

    logic [NUM_W-1:0] n_num;
    logic [1:0]       n_rem;

    // Long division MSB first; the partial remainder stays below three, and each
    // processed dividend bit is replaced in place by its quotient bit.
    always_comb begin
        logic [2:0] x;
        n_num = i_num;
        n_rem = i_rem;
        for (int j = 0; j < DIV_STEP; j++) begin
            x = {n_rem, n_num[BIT_HI-j]};
            if (x >= 3'd3) begin
                n_num[BIT_HI-j] = 1'b1;
                n_rem = 2'(x - 3'd3);
            end else begin
                n_num[BIT_HI-j] = 1'b0;
                n_rem = x[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= n_num;
            o_rem <= n_rem;
            o_neg <= i_neg;
        end
    end

endmodule

FILE: sv/lbmc_lane.sv
// One relaxation lane: equilibrium from C and its factor, BGK relax, saturate.
module lbmc_lane #(
    parameter int DIST_WIDTH = 32,
    parameter int VEL_WIDTH  = 16
) (
    input  logic                                   i_clk,
    input  logic [lbmc_pkg::div_stages(DIST_WIDTH, VEL_WIDTH)+5:0] i_en,
    input  logic signed [DIST_WIDTH+2:0]           i_conc,
    input  logic signed [lbmc_pkg::fac_width(VEL_WIDTH)-1:0] i_fac,
    input  logic signed [DIST_WIDTH-1:0]           i_f,
    input  logic [lbmc_pkg::TAU_WIDTH-1:0]         i_tau,
    output logic signed [DIST_WIDTH-1:0]           o_res,
    output logic                                   o_sat
);
    import lbmc_pkg::*;

    localparam int DW  = DIST_WIDTH;
    localparam int CW  = DW + 3;
    localparam int FW  = fac_width(VEL_WIDTH);
    localparam int PW  = CW + FW;
    localparam int MW  = PW - VEL_FRAC - 1;
    localparam int ND  = div_stages(DIST_WIDTH, VEL_WIDTH);
    localparam int MP  = ND * DIV_STEP;
    localparam int EW  = MW + 1;
    localparam int DDW = ((EW > DW) ? EW : DW) + 1;
    localparam int P2W = DDW + TAU_WIDTH + 1;
    localparam int QW2 = P2W - TAU_FRAC;
    localparam int SW  = ((QW2 > DW) ? QW2 : DW) + 1;

    // Lane stage numbers.
    localparam int ST_P = 0;
    localparam int ST_M = 1;
    localparam int ST_D = 2;
    localparam int ST_E = ND + 2;
    localparam int ST_T = ND + 3;
    localparam int ST_R = ND + 4;
    localparam int ST_S = ND + 5;

    localparam logic [PW-1:0]  HALF_EQ  = PW'(3) << VEL_FRAC;
    localparam logic [P2W-1:0] HALF_TAU = P2W'(1) << (TAU_FRAC - 1);
    localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic signed [DW-1:0]  r_fd [0:ST_R];
    logic signed [PW-1:0]  r_p;
    logic [MW-1:0]         r_m;
    logic                  r_neg1;
    logic signed [DDW-1:0] r_d;
    logic signed [P2W-1:0] r_p2;
    logic [QW2-1:0]        r_q2;
    logic                  r_neg2;

    logic [MP-1:0] w_num [0:ND];
    logic [1:0]    w_rem [0:ND];
    logic          w_neg [0:ND];

    logic [PW-1:0]         n_mag;
    logic [PW-1:0]         n_msum;
    logic signed [EW-1:0]  n_eq;
    logic [P2W-1:0]        n_mag2;
    logic [P2W-1:0]        n_qsum;
    logic signed [SW-1:0]  n_fx;
    logic signed [SW-1:0]  n_qx;
    logic signed [SW-1:0]  n_sum;
    logic signed [TAU_WIDTH:0] w_tau;

    assign w_tau = {1'b0, i_tau};

    // The distribution travels beside its item so it is at hand for the relax step.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_fd[0] <= i_f;
        end
        for (int j = 1; j <= ST_R; j++) begin
            if (i_en[j]) begin
                r_fd[j] <= r_fd[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_P]) begin
            r_p <= PW'(i_conc) * PW'(i_fac);
        end
    end

    // Magnitude of C*factor plus half of 6 * 2^frac, over 2^(frac+1); the truncating
    // divide by three that follows completes the rounded divide.
    always_comb begin
        n_mag  = r_p[PW-1] ? PW'(-r_p) : PW'(r_p);
        n_msum = n_mag + HALF_EQ;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_M]) begin
            r_m    <= n_msum[PW-1:VEL_FRAC+1];
            r_neg1 <= r_p[PW-1];
        end
    end

    assign w_num[0] = MP'(r_m);
    assign w_rem[0] = 2'd0;
    assign w_neg[0] = r_neg1;

    for (genvar s = 0; s < ND; s++) begin : g_div
        lbmc_div3 #(
            .NUM_W  (MP),
            .BIT_HI (MP - 1 - s * DIV_STEP)
        ) u_div3 (
            .i_clk (i_clk),
            .i_en  (i_en[ST_D+s]),
            .i_num (w_num[s]),
            .i_rem (w_rem[s]),
            .i_neg (w_neg[s]),
            .o_num (w_num[s+1]),
            .o_rem (w_rem[s+1]),
            .o_neg (w_neg[s+1])
        );
    end

    always_comb begin
        n_eq = w_neg[ND] ? -$signed({1'b0, w_num[ND][MW-1:0]})
                         : $signed({1'b0, w_num[ND][MW-1:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_E]) begin
            r_d <= DDW'(n_eq) - DDW'(r_fd[ST_E-1]);
        end
        if (i_en[ST_T]) begin
            r_p2 <= P2W'(r_d) * P2W'(w_tau);
        end
    end

    always_comb begin
        n_mag2 = r_p2[P2W-1] ? P2W'(-r_p2) : P2W'(r_p2);
        n_qsum = n_mag2 + HALF_TAU;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_R]) begin
            r_q2   <= n_qsum[P2W-1:TAU_FRAC];
            r_neg2 <= r_p2[P2W-1];
        end
    end

    always_comb begin
        n_fx  = SW'(r_fd[ST_R]);
        n_qx  = $signed(SW'(r_q2));
        n_sum = r_neg2 ? n_fx - n_qx : n_fx + n_qx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_S]) begin
            if (n_sum > SMAX) begin
                o_res <= SMAX[DW-1:0];
                o_sat <= 1'b1;
            end else if (n_sum < SMIN) begin
                o_res <= SMIN[DW-1:0];
                o_sat <= 1'b1;
            end else begin
                o_res <= n_sum[DW-1:0];
                o_sat <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/lbmc_pipe_ctl.sv
// Per-stage valid bits and load enables; a stage moves when it is empty or the next one moves.
module lbmc_pipe_ctl #(
    parameter int NS = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    output logic [NS-1:0] o_en,
    output logic          o_in_stall,
    output logic          o_out_valid
);
    import lbmc_pkg::*;

    logic [NS-1:0] r_valid;
    logic [NS-1:0] n_valid;
    logic [NS:0]   w_rdy;

    always_comb begin
        w_rdy[NS] = !i_out_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
        o_en[0]    = i_in_valid && w_rdy[0];
        n_valid[0] = w_rdy[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < NS; k++) begin
            o_en[k]    = r_valid[k-1] && w_rdy[k];
            n_valid[k] = w_rdy[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_valid[NS-1];

endmodule

FILE: sv/lbm_d2q5_bgk_collision.sv
// Top level of the D2Q5 BGK collision: concentration front end, five lanes, swap and merge.
//
//   channel   direction  handshake                    word
//   in        input      i_in_valid / o_in_stall      five distributions, two velocities
//   out       output     o_out_valid / i_out_stall    five relaxed values, saturated flag
//   cfg       input      i_cfg_we                     inverse relaxation time
//
// One node is accepted per cycle while o_in_stall is low. The chain of divide-by-three
// stages that round the equilibria sets the depth of the pipeline.
// Reset is synchronous and active low; it empties the pipeline and loads 1/tau = 1.0.
// Each stage holds its word while the stage after it is full and stalled, so empty
// stages keep filling behind a stalled output.
module lbm_d2q5_bgk_collision #(
    parameter int DIST_WIDTH = 32,
    parameter int VEL_WIDTH  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lbmc_pkg::TAU_WIDTH-1:0]         i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [DIST_WIDTH-1:0]           i_f_rest,
    input  logic signed [DIST_WIDTH-1:0]           i_f_east,
    input  logic signed [DIST_WIDTH-1:0]           i_f_north,
    input  logic signed [DIST_WIDTH-1:0]           i_f_west,
    input  logic signed [DIST_WIDTH-1:0]           i_f_south,
    input  logic signed [VEL_WIDTH-1:0]            i_vel_x,
    input  logic signed [VEL_WIDTH-1:0]            i_vel_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [DIST_WIDTH-1:0]           o_out_rest,
    output logic signed [DIST_WIDTH-1:0]           o_out_east,
    output logic signed [DIST_WIDTH-1:0]           o_out_north,
    output logic signed [DIST_WIDTH-1:0]           o_out_west,
    output logic signed [DIST_WIDTH-1:0]           o_out_south,
    output logic                                   o_saturated
);
    import lbmc_pkg::*;

    localparam int DW = DIST_WIDTH;
    localparam int CW = DW + 3;
    localparam int FW = fac_width(VEL_WIDTH);
    localparam int ND = div_stages(DIST_WIDTH, VEL_WIDTH);
    localparam int LN = ND + 6;
    localparam int NS = LN + 2;

    localparam logic signed [FW-1:0] FAC_ONE  = FW'(1) <<< VEL_FRAC;
    localparam logic signed [FW-1:0] FAC_REST = FW'(1) <<< (VEL_FRAC + 1);

    logic [TAU_WIDTH-1:0]  r_tau;
    logic [NS-1:0]         w_en;

    logic signed [DW-1:0]  w_fin [0:NUM_LANES-1];
    logic signed [CW-1:0]  n_conc;
    logic signed [FW-1:0]  n_ux3;
    logic signed [FW-1:0]  n_uy3;
    logic signed [FW-1:0]  n_fac [0:NUM_LANES-1];

    logic signed [DW-1:0]  r_f   [0:NUM_LANES-1];
    logic signed [FW-1:0]  r_fac [0:NUM_LANES-1];
    logic signed [CW-1:0]  r_conc;

    logic signed [DW-1:0]  w_res [0:NUM_LANES-1];
    logic                  w_sat [0:NUM_LANES-1];

    logic signed [DW-1:0]  r_out_rest;
    logic signed [DW-1:0]  r_out_east;
    logic signed [DW-1:0]  r_out_north;
    logic signed [DW-1:0]  r_out_west;
    logic signed [DW-1:0]  r_out_south;
    logic                  r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau <= TAU_RESET;
        end else if (i_cfg_we) begin
            r_tau <= i_cfg_wdata;
        end
    end

    lbmc_pipe_ctl #(
        .NS (NS)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_en        (w_en),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    assign w_fin[LANE_REST]  = i_f_rest;
    assign w_fin[LANE_EAST]  = i_f_east;
    assign w_fin[LANE_NORTH] = i_f_north;
    assign w_fin[LANE_WEST]  = i_f_west;
    assign w_fin[LANE_SOUTH] = i_f_south;

    // The rest equilibrium C/3 is written as C * 2^(frac+1) / (6 * 2^frac), so all
    // five lanes share one form: round(C * factor / (6 * 2^frac)).
    always_comb begin
        n_conc = CW'(i_f_rest) + CW'(i_f_east) + CW'(i_f_north)
               + CW'(i_f_west) + CW'(i_f_south);
        n_ux3  = FW'(i_vel_x) + (FW'(i_vel_x) <<< 1);
        n_uy3  = FW'(i_vel_y) + (FW'(i_vel_y) <<< 1);
        n_fac[LANE_REST]  = FAC_REST;
        n_fac[LANE_EAST]  = FAC_ONE + n_ux3;
        n_fac[LANE_NORTH] = FAC_ONE + n_uy3;
        n_fac[LANE_WEST]  = FAC_ONE - n_ux3;
        n_fac[LANE_SOUTH] = FAC_ONE - n_uy3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_conc <= n_conc;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_f[i]   <= w_fin[i];
                r_fac[i] <= n_fac[i];
            end
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        lbmc_lane #(
            .DIST_WIDTH (DIST_WIDTH),
            .VEL_WIDTH  (VEL_WIDTH)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en[LN:1]),
            .i_conc (r_conc),
            .i_fac  (r_fac[i]),
            .i_f    (r_f[i]),
            .i_tau  (r_tau),
            .o_res  (w_res[i]),
            .o_sat  (w_sat[i])
        );
    end

    // Merge: swap opposite directions for streaming and combine the clip flags.
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out_rest  <= w_res[LANE_REST];
            r_out_east  <= w_res[LANE_WEST];
            r_out_north <= w_res[LANE_SOUTH];
            r_out_west  <= w_res[LANE_EAST];
            r_out_south <= w_res[LANE_NORTH];
            r_sat       <= w_sat[LANE_REST] | w_sat[LANE_EAST] | w_sat[LANE_NORTH]
                         | w_sat[LANE_WEST] | w_sat[LANE_SOUTH];
        end
    end

    assign o_out_rest  = r_out_rest;
    assign o_out_east  = r_out_east;
    assign o_out_north = r_out_north;
    assign o_out_west  = r_out_west;
    assign o_out_south = r_out_south;
    assign o_saturated = r_sat;

endmodule
